>>> design/sha1_digest_engine_defines.svh
// Assertion helpers for the digest engine back end.
// Each one expects signals named clk and rst in the module that uses it.
`ifndef SHA1_DIGEST_ENGINE_DEFINES_SVH
`define SHA1_DIGEST_ENGINE_DEFINES_SVH

`define SHA1DE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SHA1DE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sha1de_pkg.sv
`default_nettype none

package sha1de_pkg;

  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] POS_LAST    = 4'(BLOCK_WORDS - 1);
  localparam logic [3:0] POS_LEN_HI  = 4'(BLOCK_WORDS - 2);
  localparam logic [6:0] ROUND_LAST  = 7'(ROUNDS - 1);
  localparam logic [2:0] DIGEST_LAST = 3'(DIGEST_WORDS - 1);
  localparam logic [2:0] FULL_BYTES  = 3'd4;

  localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;
  localparam logic [31:0] PAD_MARK = 32'h80000000;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } digest_item_t;

  typedef enum logic [1:0] {
    CMD_WORD,
    CMD_FINAL_FULL,
    CMD_FINAL_PART
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
    logic [2:0]  nbytes;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_xfer_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PAD,
    B_ROUND,
    B_ADD,
    B_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN_LO,
    PH_DONE
  } pad_phase_t;

endpackage

`default_nettype wire

>>> design/sha1de_front.sv
`default_nettype none

module sha1de_front import sha1de_pkg::*; (
  input  logic        msg_valid,
  output logic        msg_stall,
  input  msg_item_t   msg,
  input  logic        queue_full,
  output queue_xfer_t queue_in
);

  logic [2:0] nb;

  // Bytes beyond four on a final word count as four.
  always_comb begin
    nb = (msg.valid_bytes > FULL_BYTES) ? FULL_BYTES : msg.valid_bytes;
  end

  always_comb begin
    queue_in.valid      = msg_valid && !queue_full;
    queue_in.cmd.kind   = CMD_WORD;
    queue_in.cmd.word   = msg.data_word;
    queue_in.cmd.nbytes = FULL_BYTES;
    if (msg.end_of_message) begin
      queue_in.cmd.nbytes = nb;
      if (nb == FULL_BYTES) begin
        queue_in.cmd.kind = CMD_FINAL_FULL;
      end else begin
        // The pad marker lands in the first unused byte, which needs no extra word.
        queue_in.cmd.kind = CMD_FINAL_PART;
        case (nb)
          3'd0:    queue_in.cmd.word = PAD_MARK;
          3'd1:    queue_in.cmd.word = {msg.data_word[31:24], 24'h800000};
          3'd2:    queue_in.cmd.word = {msg.data_word[31:16], 16'h8000};
          3'd3:    queue_in.cmd.word = {msg.data_word[31:8], 8'h80};
          default: queue_in.cmd.word = msg.data_word;
        endcase
      end
    end
  end

  assign msg_stall = queue_full;

endmodule

`default_nettype wire

>>> design/sha1de_fifo.sv
`default_nettype none

module sha1de_fifo import sha1de_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_xfer_t queue_in,
  output logic        full,
  output queue_xfer_t head,
  input  logic        pop
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (queue_in.valid) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (queue_in.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!queue_in.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (queue_in.valid) begin
      entries[wr_ptr] <= queue_in.cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/sha1de_back.sv
`default_nettype none

`include "sha1_digest_engine_defines.svh"

module sha1de_back import sha1de_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  queue_xfer_t  head,
  output logic         pop,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_item_t digest
);

  back_state_t state, state_next;
  pad_phase_t  phase, phase_next;
  logic        final_active;
  logic [3:0]  pos;
  logic [6:0]  round;
  logic [63:0] bitlen;
  logic [2:0]  idx;

  logic [DIGEST_WORDS-1:0][31:0] chain;
  logic [BLOCK_WORDS-1:0][31:0]  sched;
  logic [31:0] a, b, c, d, e;

  logic        push_en;
  logic [31:0] push_word;
  logic        len_add;
  logic        out_load;
  logic [31:0] f, k, t, w_new, w_mix;

  always_comb begin
    state_next = state;
    phase_next = phase;
    pop        = 1'b0;
    push_en    = 1'b0;
    push_word  = '0;
    len_add    = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          push_en   = 1'b1;
          push_word = head.cmd.word;
          len_add   = 1'b1;
          if (head.cmd.kind == CMD_FINAL_FULL) begin
            phase_next = PH_MARK;
          end else begin
            phase_next = PH_ZERO;
          end
          if (pos == POS_LAST) begin
            state_next = B_ROUND;
          end else if (head.cmd.kind != CMD_WORD) begin
            state_next = B_PAD;
          end
        end
      end
      B_PAD: begin
        case (phase)
          PH_MARK: begin
            push_en    = 1'b1;
            push_word  = PAD_MARK;
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            push_en = 1'b1;
            // Zero words run until the length fits in the last two slots.
            if (pos == POS_LEN_HI) begin
              push_word  = bitlen[63:32];
              phase_next = PH_LEN_LO;
            end
          end
          PH_LEN_LO: begin
            push_en    = 1'b1;
            push_word  = bitlen[31:0];
            phase_next = PH_DONE;
          end
          default: begin
            state_next = B_OUT;
          end
        endcase
        if (push_en && pos == POS_LAST) begin
          state_next = B_ROUND;
        end
      end
      B_ROUND: begin
        if (round == ROUND_LAST) begin
          state_next = B_ADD;
        end
      end
      B_ADD: begin
        state_next = final_active ? B_PAD : B_IDLE;
      end
      B_OUT: begin
        out_load = !digest_valid || !digest_stall;
        if (out_load && idx == DIGEST_LAST) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_ROUND0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K_ROUND1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_ROUND2;
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND3;
    end
    t     = {a[26:0], a[31:27]} + f + e + k + sched[0];
    w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      phase        <= PH_MARK;
      final_active <= 1'b0;
      pos          <= '0;
      round        <= '0;
      bitlen       <= '0;
      chain        <= H_INIT;
      idx          <= '0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (state == B_IDLE && head.valid && head.cmd.kind != CMD_WORD) begin
        final_active <= 1'b1;
      end
      if (push_en) begin
        pos <= pos + 1'b1;
      end
      if (len_add) begin
        bitlen <= bitlen + {58'd0, head.cmd.nbytes, 3'b000};
      end
      if (state == B_ROUND) begin
        round <= (round == ROUND_LAST) ? '0 : round + 1'b1;
      end
      if (state == B_ADD) begin
        chain <= {chain[4] + e, chain[3] + d, chain[2] + c, chain[1] + b, chain[0] + a};
      end
      if (out_load) begin
        digest_valid <= 1'b1;
        if (idx == DIGEST_LAST) begin
          idx          <= '0;
          chain        <= H_INIT;
          bitlen       <= '0;
          final_active <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (!digest_stall) begin
        digest_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      sched <= {push_word, sched[BLOCK_WORDS-1:1]};
    end else if (state == B_ROUND) begin
      sched <= {w_new, sched[BLOCK_WORDS-1:1]};
    end
    if (push_en && pos == POS_LAST) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == B_ROUND) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    if (out_load) begin
      digest.digest_word  <= chain[idx];
      digest.digest_index <= idx;
      digest.digest_last  <= (idx == DIGEST_LAST);
    end
  end

  `SHA1DE_ASSERT_SAME(a_round_range, state == B_ROUND, round <= ROUND_LAST, "round index out of range")
  `SHA1DE_ASSERT_SAME(a_block_aligned, state == B_ROUND || state == B_ADD, pos == '0, "compression started on a partial block")
  `SHA1DE_ASSERT_SAME(a_pad_final, state == B_PAD, final_active, "padding without a final word")
  `SHA1DE_ASSERT_NEXT(a_reload, out_load && idx == DIGEST_LAST, chain == H_INIT && bitlen == '0, "chaining value not reloaded after digest")

endmodule

`default_nettype wire

>>> design/sha1_digest_engine.sv
// SHA-1 digest engine.
// Message words enter on the msg channel (msg_valid, msg_stall, msg), first byte
// in the top bits; the word with end_of_message set closes the message and gives
// its used byte count in valid_bytes. The digest leaves on the digest channel as
// five transactions, digest_index 0 to 4, with digest_last on the fifth.
// A two-entry queue buffers the message words. The back end loads one word per
// cycle into the block buffer while it is idle and the queue holds words; a full
// 16-word block then runs its 80 rounds through the single round datapath and
// is folded into the chaining value.
// After a final word the back end inserts the padding and length at one word per
// cycle between compressions, compresses one or two blocks in all, and then
// offers one digest word per cycle while the digest channel does not stall.
// A stall on the digest channel holds the current word; the back end waits, the
// queue fills and msg_stall rises until the digest drains.
// Reset loads the initial chaining value, clears the length and empties the queue;
// no clearing pass runs, so the block takes words in the first cycle after reset.
`default_nettype none

module sha1_digest_engine import sha1de_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         msg_valid,
  output logic         msg_stall,
  input  msg_item_t    msg,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_item_t digest
);

  queue_xfer_t queue_in;
  queue_xfer_t head;
  logic        queue_full;
  logic        pop;

  sha1de_front u_front (
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg        (msg),
    .queue_full (queue_full),
    .queue_in   (queue_in)
  );

  sha1de_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .queue_in (queue_in),
    .full     (queue_full),
    .head     (head),
    .pop      (pop)
  );

  sha1de_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

`default_nettype wire

>>> dv/sha1_digest_tb_pkg.sv
`timescale 1ns / 1ps

package sha1_digest_tb_pkg;
  import sha1de_pkg::*;

  class sha1_expected_digests;
    bit [31:0]    chain [DIGEST_WORDS];
    bit [31:0]    block_buf [BLOCK_WORDS];
    bit [63:0]    msg_bits;
    bit [3:0]     fill;
    digest_item_t digest_q [$];
    int unsigned  errors;

    function new();
      for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = H_INIT[i];
      for (int i = 0; i < BLOCK_WORDS; i++) block_buf[i] = '0;
      msg_bits = '0;
      fill = '0;
      errors = 0;
    endfunction

    function bit [31:0] rotl(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress_block();
      bit [31:0] sched [ROUNDS];
      bit [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < BLOCK_WORDS; r++) sched[r] = block_buf[r];
      for (int r = BLOCK_WORDS; r < ROUNDS; r++)
        sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < ROUNDS; r++) begin
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_ROUND0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_ROUND1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_ROUND2;
        end else begin
          f = b ^ c ^ d;
          k = K_ROUND3;
        end
        t = rotl(a, 5) + f + e + k + sched[r];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb_word(bit [31:0] w);
      block_buf[fill] = w;
      fill++;
      if (fill == 0) compress_block();
    endfunction

    // Called once per accepted message transaction.
    function void note_word(msg_item_t item);
      bit [2:0]     nbytes;
      bit [31:0]    keep;
      digest_item_t exp;
      if (!item.end_of_message) begin
        absorb_word(item.data_word);
        msg_bits += 64'd32;
        return;
      end
      nbytes = (item.valid_bytes > FULL_BYTES) ? FULL_BYTES : item.valid_bytes;
      msg_bits += 64'({nbytes, 3'b000});
      if (nbytes == FULL_BYTES) begin
        absorb_word(item.data_word);
        absorb_word(PAD_MARK);
      end else begin
        keep = (nbytes == 0) ? 32'h0 : ~(32'hFFFFFFFF >> (8 * nbytes));
        absorb_word((item.data_word & keep) | (PAD_MARK >> (8 * nbytes)));
      end
      while (fill != POS_LEN_HI) absorb_word(32'h0);
      absorb_word(msg_bits[63:32]);
      absorb_word(msg_bits[31:0]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        exp.digest_word  = chain[i];
        exp.digest_index = 3'(i);
        exp.digest_last  = (3'(i) == DIGEST_LAST);
        digest_q.push_back(exp);
      end
      for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = H_INIT[i];
      msg_bits = '0;
      fill = '0;
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("MISMATCH at %0t ns: %s expected %h got %h", $time, what, want, got);
      errors++;
    endtask

    task check_digest(digest_item_t got);
      digest_item_t exp;
      if (digest_q.size() == 0) begin
        report("digest transaction with none pending", 32'h0, got.digest_word);
        return;
      end
      exp = digest_q.pop_front();
      if (got.digest_word !== exp.digest_word)
        report("digest_word", exp.digest_word, got.digest_word);
      if (got.digest_index !== exp.digest_index)
        report("digest_index", 32'(exp.digest_index), 32'(got.digest_index));
      if (got.digest_last !== exp.digest_last)
        report("digest_last", 32'(exp.digest_last), 32'(got.digest_last));
    endtask

    function int pending();
      return digest_q.size();
    endfunction
  endclass

endpackage

>>> dv/tb_sha1_digest_engine.sv
`timescale 1ns / 1ps

module tb_sha1_digest_engine;
  import sha1de_pkg::*;
  import sha1_digest_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_WORDS = 200;
  localparam int          DRAIN_CYCLES = 300;

  logic         clk;
  logic         rst          = 1'b1;
  logic         msg_valid    = 1'b0;
  logic         msg_stall;
  msg_item_t    msg          = '0;
  logic         digest_valid;
  logic         digest_stall = 1'b0;
  digest_item_t digest;

  sha1_expected_digests digests;
  int                   words_sent;

  sha1_digest_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic msg_item_t make_word(logic [31:0] data, logic [2:0] nbytes, logic eom);
    msg_item_t item;
    item.data_word      = data;
    item.valid_bytes    = nbytes;
    item.end_of_message = eom;
    return item;
  endfunction

  // Valid stays high across back-to-back transactions; it is only lowered
  // when a gap follows, so it never sees two updates in one step.
  task automatic send_word(input msg_item_t item, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg       <= item;
    msg_valid <= 1'b1;
    do @(posedge clk); while (msg_stall);
    digests.note_word(item);
    words_sent++;
  endtask

  task automatic wait_for_digests();
    msg_valid <= 1'b0;
    do @(posedge clk); while (digests.pending() != 0);
  endtask

  task automatic send_message(input int len, input bit no_gap);
    for (int i = 0; i < len; i++)
      send_word(make_word($urandom, 3'($urandom_range(0, 7)), 1'b0), no_gap);
    send_word(make_word($urandom, 3'($urandom_range(0, 7)), 1'b1), no_gap);
  endtask

  initial begin : digest_sink
    int hold;
    bit steady;
    hold = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && digest_valid && !digest_stall) begin
        digests.check_digest(digest);
        if ($urandom_range(0, 15) == 0) steady = !steady;
        hold = steady ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        digest_stall <= 1'b1;
        hold--;
      end else begin
        digest_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int len;
    digests = new();
    words_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Final words alone: empty message, partial words, a full word, and
    // byte counts above four, with all-ones data on some to expose unmasked bytes.
    send_word(make_word(32'hFFFFFFFF, 3'd0, 1'b1), 1'b0);
    send_word(make_word(32'hFFFFFFFF, 3'd1, 1'b1), 1'b0);
    send_word(make_word(32'h00000000, 3'd2, 1'b1), 1'b1);
    send_word(make_word(32'hFFFFFFFF, 3'd3, 1'b1), 1'b0);
    send_word(make_word(32'h61626364, 3'd4, 1'b1), 1'b0);
    send_word(make_word(32'hA5A5A5A5, 3'd5, 1'b1), 1'b1);
    send_word(make_word(32'hFFFFFFFF, 3'd7, 1'b1), 1'b0);

    // Fourteen words then a partial final word: the length no longer fits
    // and a second block is needed.
    for (int i = 0; i < 14; i++)
      send_word(make_word((i % 2) ? 32'hFFFFFFFF : 32'h00000000, 3'(i % 8), 1'b0), 1'b0);
    send_word(make_word(32'h5A5A5A5A, 3'd3, 1'b1), 1'b0);

    wait_for_digests();

    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 20);
      else if (pick < 9) len = $urandom_range(21, 40);
      else len = $urandom_range(41, 70);
      send_message(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) wait_for_digests();
    end

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digests.errors == 0 && digests.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/sha1de_pkg.sv
design/sha1de_front.sv
design/sha1de_fifo.sv
design/sha1de_back.sv
design/sha1_digest_engine.sv
dv/sha1_digest_tb_pkg.sv
dv/tb_sha1_digest_engine.sv
